FILE: src/assert_macros.svh
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define WSHT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("wsht check failed");

// Next-cycle implication, masked while reset is asserted.
`define WSHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("wsht check failed");

// Condition that must hold on the cycle after reset is sampled low.
`define WSHT_ASSERT_RESET(lbl, clk, rstn, cons) \
  lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) \
    else $error("wsht reset check failed");

`endif

FILE: src/wsht_pkg.sv
package wsht_pkg;

  localparam int NUM_LANES   = 4;
  localparam int CMD_W       = 2;
  localparam int GAIN_W      = 8;
  localparam int LEVEL_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TOTAL_W     = 22;
  localparam int DIFF_W      = 23;
  localparam int START_SUM_W = 16;
  localparam int WMEAN_W     = START_SUM_W + GAIN_W;

  localparam int START_WINDOW_DEF = 5;
  localparam int BLOCK_LENGTH_DEF = 20;
  localparam int SAMPLE_BITS_DEF  = 12;

  // Reciprocal multiply then gain multiply inside each lane
  localparam int DIV_LAT = 2;
  localparam int WAIT_W  = $clog2(DIV_LAT + 1);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [GAIN_W-1:0]  GAIN_RESET       = 8'd10;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH_RESET = 16'd3400;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW_RESET  = 16'd3000;
  localparam logic [LEVEL_W-1:0] TOLERANCE_RESET  = 16'd500;

  localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd6;

  typedef struct packed {
    logic load;
    logic start_item;
    logic close;
  } lane_ctl_t;

  typedef struct packed {
    logic s2_load;
    logic s3_load;
  } merge_ctl_t;

endpackage

FILE: src/wsht_lane.sv
module wsht_lane #(
  parameter int SAMPLE_BITS  = wsht_pkg::SAMPLE_BITS_DEF,
  parameter int START_WINDOW = wsht_pkg::START_WINDOW_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  wsht_pkg::lane_ctl_t                     ctl,
  input  logic [SAMPLE_BITS-1:0]                  sample,
  input  logic [wsht_pkg::GAIN_W-1:0]             gain,
  output logic [SAMPLE_BITS+wsht_pkg::GAIN_W-1:0] prod,
  output logic [wsht_pkg::WMEAN_W-1:0]            wmean
);
  import wsht_pkg::*;

  localparam int PROD_W    = SAMPLE_BITS + GAIN_W;
  localparam int ACC_X_W   = START_SUM_W + 1;
  localparam int DIVISOR   = START_WINDOW - 2;
  localparam int DIV_LOG   = $clog2(DIVISOR);
  localparam int DIV_SHIFT = START_SUM_W + DIV_LOG;
  localparam int RECIP_W   = START_SUM_W + 1;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int QPROD_W   = DIV_SHIFT + START_SUM_W + 1;

  logic [START_SUM_W-1:0] acc_sum_r, acc_sum_nxt;
  logic [SAMPLE_BITS-1:0] acc_min_r, acc_min_nxt;
  logic [SAMPLE_BITS-1:0] acc_max_r, acc_max_nxt;
  logic [ACC_X_W-1:0]     sum_ext, sum_wide, cut;
  logic [START_SUM_W-1:0] trim_nxt;
  logic [PROD_W-1:0]      prod_r;
  logic [START_SUM_W-1:0] trim_r, quot_r;
  logic [WMEAN_W-1:0]     wmean_r;
  logic [QPROD_W-1:0]     qprod;

  always_comb begin
    sum_ext     = {1'b0, acc_sum_r} + ACC_X_W'(sample);
    acc_sum_nxt = sum_ext[START_SUM_W] ? '1 : sum_ext[START_SUM_W-1:0];
    acc_min_nxt = (sample < acc_min_r) ? sample : acc_min_r;
    acc_max_nxt = (sample > acc_max_r) ? sample : acc_max_r;
    sum_wide    = {1'b0, acc_sum_nxt};
    cut         = ACC_X_W'(acc_min_nxt) + ACC_X_W'(acc_max_nxt);
    trim_nxt    = (sum_wide >= cut) ? START_SUM_W'(sum_wide - cut) : '0;
  end

  // divide by the trimmed window length: reciprocal multiply, exact for 16-bit sums
  assign qprod = QPROD_W'(trim_r) * QPROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_sum_r <= '0;
      acc_min_r <= '1;
      acc_max_r <= '0;
    end else if (ctl.load && ctl.start_item) begin
      if (ctl.close) begin
        acc_sum_r <= '0;
        acc_min_r <= '1;
        acc_max_r <= '0;
      end else begin
        acc_sum_r <= acc_sum_nxt;
        acc_min_r <= acc_min_nxt;
        acc_max_r <= acc_max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= PROD_W'(sample) * PROD_W'(gain);
      trim_r <= trim_nxt;
    end
    quot_r  <= qprod[DIV_SHIFT +: START_SUM_W];
    wmean_r <= WMEAN_W'(quot_r) * WMEAN_W'(gain);
  end

  assign prod  = prod_r;
  assign wmean = wmean_r;

endmodule

FILE: src/wsht_merge.sv
module wsht_merge #(
  parameter int SAMPLE_BITS  = wsht_pkg::SAMPLE_BITS_DEF,
  parameter int BLOCK_LENGTH = wsht_pkg::BLOCK_LENGTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  wsht_pkg::merge_ctl_t                    ctl,
  input  logic [wsht_pkg::CMD_W-1:0]              s1_cmd,
  input  logic                                    s1_close,
  input  logic [SAMPLE_BITS+wsht_pkg::GAIN_W-1:0] prod [wsht_pkg::NUM_LANES],
  input  logic [wsht_pkg::WMEAN_W-1:0]            wmean [wsht_pkg::NUM_LANES],
  input  logic [wsht_pkg::LEVEL_W-1:0]            level_high,
  input  logic [wsht_pkg::LEVEL_W-1:0]            level_low,
  input  logic [wsht_pkg::LEVEL_W-1:0]            tolerance,
  output logic                                    trigger,
  output logic [wsht_pkg::TOTAL_W-1:0]            total,
  output logic signed [wsht_pkg::DIFF_W-1:0]      difference,
  output logic [wsht_pkg::TOTAL_W-1:0]            baseline,
  output logic                                    rezeroed
);
  import wsht_pkg::*;

  localparam int PROD_W   = SAMPLE_BITS + GAIN_W;
  localparam int PSUM_W   = PROD_W + 2;
  localparam int PSUM_X_W = (PSUM_W > TOTAL_W) ? PSUM_W : TOTAL_W;
  localparam int WSUM_W   = WMEAN_W + 2;
  localparam int BC_W     = $clog2(BLOCK_LENGTH + 1);

  logic [PSUM_X_W-1:0]       psum;
  logic [WSUM_W-1:0]         wsum;
  logic [TOTAL_W-1:0]        total_sat, base_sat;

  logic [CMD_W-1:0]          s2_cmd_r;
  logic                      s2_close_r;
  logic [TOTAL_W-1:0]        s2_total_r, s2_base_r;

  logic                      trigger_r, trigger_nxt;
  logic [TOTAL_W-1:0]        baseline_r, baseline_nxt;
  logic [TOTAL_W-1:0]        blk_min_r, blk_min_nxt;
  logic [TOTAL_W-1:0]        blk_max_r, blk_max_nxt;
  logic [BC_W-1:0]           blk_cnt_r, blk_cnt_nxt;
  logic [TOTAL_W-1:0]        out_total_r;
  logic signed [DIFF_W-1:0]  out_diff_r;
  logic                      out_rez_r, rez_nxt;

  logic signed [DIFF_W-1:0]  diff_v, lvl_hi_s, lvl_lo_s;
  logic [TOTAL_W-1:0]        min_c, max_c, spread;
  logic [BC_W-1:0]           cnt_inc;

  // Adder stage: total of the lane products and of the lane weighted means
  always_comb begin
    psum = '0;
    wsum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      psum = psum + PSUM_X_W'(prod[i]);
      wsum = wsum + WSUM_W'(wmean[i]);
    end
    total_sat = (psum > PSUM_X_W'(TOTAL_MAX)) ? TOTAL_MAX : psum[TOTAL_W-1:0];
    base_sat  = (wsum > WSUM_W'(TOTAL_MAX)) ? TOTAL_MAX : wsum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      s2_cmd_r   <= s1_cmd;
      s2_close_r <= s1_close;
      s2_total_r <= total_sat;
      s2_base_r  <= base_sat;
    end
  end

  // Decision stage
  assign diff_v   = $signed(DIFF_W'(s2_total_r) - DIFF_W'(baseline_r));
  assign lvl_hi_s = $signed(DIFF_W'(level_high));
  assign lvl_lo_s = $signed(DIFF_W'(level_low));
  assign min_c    = (s2_total_r < blk_min_r) ? s2_total_r : blk_min_r;
  assign max_c    = (s2_total_r > blk_max_r) ? s2_total_r : blk_max_r;
  assign spread   = max_c - min_c;
  assign cnt_inc  = blk_cnt_r + BC_W'(1);

  always_comb begin
    trigger_nxt  = trigger_r;
    baseline_nxt = baseline_r;
    blk_min_nxt  = blk_min_r;
    blk_max_nxt  = blk_max_r;
    blk_cnt_nxt  = blk_cnt_r;
    rez_nxt      = 1'b0;
    if (s2_cmd_r == CMD_START) begin
      if (s2_close_r) begin
        baseline_nxt = s2_base_r;
      end
    end else begin
      priority if (diff_v >= lvl_hi_s) begin
        trigger_nxt = 1'b1;
      end else if (diff_v < lvl_lo_s) begin
        trigger_nxt = 1'b0;
      end else begin
        // inside the band: hold the level
        trigger_nxt = trigger_r;
      end
      if (s2_cmd_r == CMD_TICK) begin
        if (cnt_inc == BC_W'(BLOCK_LENGTH)) begin
          if (spread <= TOTAL_W'(tolerance)) begin
            baseline_nxt = s2_total_r;
            rez_nxt      = 1'b1;
          end
          blk_min_nxt = '1;
          blk_max_nxt = '0;
          blk_cnt_nxt = '0;
        end else begin
          blk_min_nxt = min_c;
          blk_max_nxt = max_c;
          blk_cnt_nxt = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_r  <= 1'b0;
      baseline_r <= '0;
      blk_min_r  <= '1;
      blk_max_r  <= '0;
      blk_cnt_r  <= '0;
    end else if (ctl.s3_load) begin
      trigger_r  <= trigger_nxt;
      baseline_r <= baseline_nxt;
      blk_min_r  <= blk_min_nxt;
      blk_max_r  <= blk_max_nxt;
      blk_cnt_r  <= blk_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_load) begin
      out_total_r <= s2_total_r;
      out_diff_r  <= diff_v;
      out_rez_r   <= rez_nxt;
    end
  end

  assign trigger    = trigger_r;
  assign total      = out_total_r;
  assign difference = out_diff_r;
  assign baseline   = baseline_r;
  assign rezeroed   = out_rez_r;

endmodule

FILE: src/weighted_sum_hysteresis_trigger.sv
// Path: an input transfer passes the lane product, stage-two sum and output registers;
//   a window-closing startup sample also waits on the lane reciprocal and gain multiplies.
// Throughput: one item per cycle while the output is not stalled; a window-closing startup
//   sample holds the input side while the lane divider pipeline settles.
// Reset: synchronous, active low; clears the pipeline, the trigger, baseline and all
//   accumulators, and returns every configuration register to its default setting.
module weighted_sum_hysteresis_trigger #(
  parameter int SAMPLE_BITS  = wsht_pkg::SAMPLE_BITS_DEF,
  parameter int START_WINDOW = wsht_pkg::START_WINDOW_DEF,
  parameter int BLOCK_LENGTH = wsht_pkg::BLOCK_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wsht_pkg::CMD_W-1:0]          in_command,
  input  logic [SAMPLE_BITS-1:0]              in_sample_one,
  input  logic [SAMPLE_BITS-1:0]              in_sample_two,
  input  logic [SAMPLE_BITS-1:0]              in_sample_three,
  input  logic [SAMPLE_BITS-1:0]              in_sample_four,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_trigger,
  output logic [wsht_pkg::TOTAL_W-1:0]        out_weighted_total,
  output logic signed [wsht_pkg::DIFF_W-1:0]  out_difference,
  output logic [wsht_pkg::TOTAL_W-1:0]        out_baseline_now,
  output logic                                out_rezeroed,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsht_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsht_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wsht_pkg::*;

  localparam int SC_W   = $clog2(START_WINDOW);
  localparam int PROD_W = SAMPLE_BITS + GAIN_W;

  // Configuration registers
  logic [GAIN_W-1:0]  gain_r [NUM_LANES];
  logic [LEVEL_W-1:0] level_high_r, level_low_r, tolerance_r;

  // Front end and stage one control
  logic               in_xfer, is_start, close;
  logic [SC_W-1:0]    start_cnt_r;
  logic               s1_valid_r, s2_valid_r, out_valid_r;
  logic [CMD_W-1:0]   s1_cmd_r;
  logic               s1_close_r;
  logic [WAIT_W-1:0]  wait_r;
  logic               s1_adv, s2_adv, s2_free, s3_free;

  logic [SAMPLE_BITS-1:0] lane_sample [NUM_LANES];
  logic [PROD_W-1:0]      lane_prod   [NUM_LANES];
  logic [WMEAN_W-1:0]     lane_wmean  [NUM_LANES];
  lane_ctl_t              lane_ctl;
  merge_ctl_t             merge_ctl;

  // Registers always writable: host must only write while the block is idle; unenforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        gain_r[i] <= GAIN_RESET;
      end
      level_high_r <= LEVEL_HIGH_RESET;
      level_low_r  <= LEVEL_LOW_RESET;
      tolerance_r  <= TOLERANCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN_ONE:   gain_r[0]    <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_TWO:   gain_r[1]    <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_THREE: gain_r[2]    <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_FOUR:  gain_r[3]    <= cfg_data[GAIN_W-1:0];
        CFG_LEVEL_HIGH: level_high_r <= cfg_data[LEVEL_W-1:0];
        CFG_LEVEL_LOW:  level_low_r  <= cfg_data[LEVEL_W-1:0];
        CFG_TOLERANCE:  tolerance_r  <= cfg_data[LEVEL_W-1:0];
        default: begin
          // index beyond the register list: drop the write
        end
      endcase
    end
  end

  // Pipeline handshake. Each stage advances when the one after it is free, so
  // a new transfer is taken even while a finished result waits at the output.
  assign s3_free  = !out_valid_r || out_ready;
  assign s2_adv   = s2_valid_r && s3_free;
  assign s2_free  = !s2_valid_r || s3_free;
  // A window-closing startup item waits in stage one for the lane divider.
  assign s1_adv   = s1_valid_r && (wait_r == '0) && s2_free;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  // Startup window count lives at the front so lanes learn of a close on transfer
  assign is_start = (in_command == CMD_START);
  assign close    = is_start && (start_cnt_r == SC_W'(START_WINDOW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_cnt_r <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wait_r      <= '0;
    end else begin
      if (in_xfer && is_start) begin
        start_cnt_r <= close ? '0 : start_cnt_r + SC_W'(1);
      end

      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end

      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Count down the lane divider latency after a closing startup item
      if (in_xfer) begin
        wait_r <= close ? WAIT_W'(DIV_LAT) : '0;
      end else if (wait_r != '0) begin
        wait_r <= wait_r - WAIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r   <= in_command;
      s1_close_r <= close;
    end
  end

  assign lane_sample[0] = in_sample_one;
  assign lane_sample[1] = in_sample_two;
  assign lane_sample[2] = in_sample_three;
  assign lane_sample[3] = in_sample_four;

  always_comb begin
    lane_ctl.load       = in_xfer;
    lane_ctl.start_item = is_start;
    lane_ctl.close      = close;
    merge_ctl.s2_load   = s1_adv;
    merge_ctl.s3_load   = s2_adv;
  end

  // One lane per channel: product, startup accumulators and trimmed-mean weighting
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    wsht_lane #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .START_WINDOW (START_WINDOW)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .sample (lane_sample[g]),
      .gain   (gain_r[g]),
      .prod   (lane_prod[g]),
      .wmean  (lane_wmean[g])
    );
  end

  // Merge: add the lanes, compare against the baseline, run the calibration block
  wsht_merge #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .BLOCK_LENGTH (BLOCK_LENGTH)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (merge_ctl),
    .s1_cmd     (s1_cmd_r),
    .s1_close   (s1_close_r),
    .prod       (lane_prod),
    .wmean      (lane_wmean),
    .level_high (level_high_r),
    .level_low  (level_low_r),
    .tolerance  (tolerance_r),
    .trigger    (out_trigger),
    .total      (out_weighted_total),
    .difference (out_difference),
    .baseline   (out_baseline_now),
    .rezeroed   (out_rezeroed)
  );

  assign out_valid = out_valid_r;

endmodule

FILE: src/wsht_checker.sv
`include "assert_macros.svh"

module wsht_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_trigger,
  input logic [wsht_pkg::TOTAL_W-1:0]       out_weighted_total,
  input logic signed [wsht_pkg::DIFF_W-1:0] out_difference,
  input logic [wsht_pkg::TOTAL_W-1:0]       out_baseline_now,
  input logic                               out_rezeroed
);
  import wsht_pkg::*;

  `WSHT_ASSERT_RESET(a_reset_empty, clk, rst_n, !out_valid)
  `WSHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `WSHT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_weighted_total) && $stable(out_difference) && $stable(out_baseline_now) && $stable(out_trigger) && $stable(out_rezeroed))
  `WSHT_ASSERT_SAME(a_rezero_base, clk, rst_n, out_valid && out_rezeroed, out_baseline_now == out_weighted_total)

endmodule

bind weighted_sum_hysteresis_trigger wsht_checker u_wsht_checker (.*);

FILE: sim/wsht_tb_pkg.sv
`timescale 1ns / 1ps
package wsht_tb_pkg;
  import wsht_pkg::*;

  typedef logic [SAMPLE_BITS_DEF-1:0] sample_t;

  typedef struct packed {
    logic               trigger;
    logic [TOTAL_W-1:0] total;
    logic [DIFF_W-1:0]  diff;
    logic [TOTAL_W-1:0] baseline;
    logic               rezeroed;
  } reading_t;

  // Shadow of the trigger: settings, hysteresis level, baseline and both
  // accumulator sets, plus the readings still owed by the block.
  class trigger_scoreboard;
    logic [GAIN_W-1:0]      gain [NUM_LANES];
    logic [LEVEL_W-1:0]     level_high;
    logic [LEVEL_W-1:0]     level_low;
    logic [LEVEL_W-1:0]     tolerance;
    logic                   trig_level;
    logic [TOTAL_W-1:0]     baseline;
    logic [TOTAL_W-1:0]     block_min;
    logic [TOTAL_W-1:0]     block_max;
    logic [5:0]             block_count;
    logic [START_SUM_W-1:0] start_sum [NUM_LANES];
    sample_t                start_min [NUM_LANES];
    sample_t                start_max [NUM_LANES];
    logic [3:0]             start_count;
    reading_t               awaited [$];
    int unsigned            mismatches;

    function new();
      foreach (gain[c]) gain[c] = GAIN_RESET;
      level_high  = LEVEL_HIGH_RESET;
      level_low   = LEVEL_LOW_RESET;
      tolerance   = TOLERANCE_RESET;
      trig_level  = 1'b0;
      baseline    = '0;
      mismatches  = 0;
      clear_block();
      clear_start();
    endfunction

    function void clear_block();
      block_min   = '1;
      block_max   = '0;
      block_count = '0;
    endfunction

    function void clear_start();
      foreach (start_sum[c]) begin
        start_sum[c] = '0;
        start_min[c] = '1;
        start_max[c] = '0;
      end
      start_count = '0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN_ONE, CFG_GAIN_TWO, CFG_GAIN_THREE, CFG_GAIN_FOUR: begin
          gain[idx[1:0]] = data[GAIN_W-1:0];
        end
        CFG_LEVEL_HIGH: level_high = data;
        CFG_LEVEL_LOW:  level_low  = data;
        CFG_TOLERANCE:  tolerance  = data;
        default: ;
      endcase
    endfunction

    function logic [TOTAL_W-1:0] weigh(sample_t s [NUM_LANES]);
      longint acc;
      longint prod;
      acc = 0;
      foreach (s[c]) begin
        prod = s[c];
        if (gain[c] != 0) acc += prod * gain[c];
      end
      return (acc > TOTAL_MAX) ? TOTAL_MAX : acc[TOTAL_W-1:0];
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, sample_t s [NUM_LANES]);
      reading_t           r;
      logic [TOTAL_W-1:0] t;
      longint             diff;
      longint             acc;
      longint             cut;
      longint             mean;
      longint             spread;
      t    = weigh(s);
      diff = longint'(t) - longint'(baseline);
      r.total    = t;
      r.diff     = diff[DIFF_W-1:0];
      r.rezeroed = 1'b0;
      if (cmd == CMD_START) begin
        // startup sample: trigger held, block accumulators left alone
        foreach (s[c]) begin
          acc = start_sum[c];
          acc += s[c];
          start_sum[c] = (acc > 16'hFFFF) ? 16'hFFFF : acc[START_SUM_W-1:0];
          if (s[c] < start_min[c]) start_min[c] = s[c];
          if (s[c] > start_max[c]) start_max[c] = s[c];
        end
        start_count = start_count + 4'd1;
        if (start_count >= START_WINDOW_DEF) begin
          acc = 0;
          foreach (s[c]) begin
            cut  = longint'(start_min[c]) + longint'(start_max[c]);
            mean = (start_sum[c] >= cut) ? (start_sum[c] - cut) / (START_WINDOW_DEF - 2) : 0;
            if (gain[c] != 0) acc += mean * gain[c];
          end
          baseline = (acc > TOTAL_MAX) ? TOTAL_MAX : acc[TOTAL_W-1:0];
          clear_start();
        end
      end else begin
        // hysteresis against the old baseline, then the calibration tick
        if (diff >= longint'(level_high)) trig_level = 1'b1;
        else if (diff < longint'(level_low)) trig_level = 1'b0;
        if (cmd == CMD_TICK) begin
          if (t < block_min) block_min = t;
          if (t > block_max) block_max = t;
          block_count = block_count + 6'd1;
          if (block_count >= BLOCK_LENGTH_DEF) begin
            spread = (block_max >= block_min) ? block_max - block_min : 0;
            if (spread <= tolerance) begin
              baseline   = t;
              r.rezeroed = 1'b1;
            end
            clear_block();
          end
        end
      end
      r.trigger  = trig_level;
      r.baseline = baseline;
      awaited.push_back(r);
    endfunction

    function void check_result(logic trig, logic [TOTAL_W-1:0] total,
                               logic [DIFF_W-1:0] diff, logic [TOTAL_W-1:0] base,
                               logic rez);
      reading_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with no reading outstanding");
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (trig !== want.trigger) begin
        $error("trigger: expected %0d, got %0d", want.trigger, trig);
        mismatches++;
      end
      if (total !== want.total) begin
        $error("weighted_total: expected %0d, got %0d", want.total, total);
        mismatches++;
      end
      if (diff !== want.diff) begin
        $error("difference: expected %0d, got %0d", $signed(want.diff), $signed(diff));
        mismatches++;
      end
      if (base !== want.baseline) begin
        $error("baseline_now: expected %0d, got %0d", want.baseline, base);
        mismatches++;
      end
      if (rez !== want.rezeroed) begin
        $error("rezeroed: expected %0d, got %0d", want.rezeroed, rez);
        mismatches++;
      end
    endfunction
  endclass

endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import wsht_pkg::*;
  import wsht_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RESET_CYCLES  = 9;
  // longest path through the block is the window-closing startup sample
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 160;
  localparam int SAMPLE_TOP    = (1 << SAMPLE_BITS_DEF) - 1;
  // register index past the end of the map; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command;
  sample_t               in_sample_one;
  sample_t               in_sample_two;
  sample_t               in_sample_three;
  sample_t               in_sample_four;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_trigger;
  logic [TOTAL_W-1:0]    out_weighted_total;
  logic signed [DIFF_W-1:0] out_difference;
  logic [TOTAL_W-1:0]    out_baseline_now;
  logic                  out_rezeroed;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  trigger_scoreboard board;
  int unsigned       send_gap_pct;
  int unsigned       recv_stall_pct;
  int unsigned       sent_items;
  int unsigned       cycle_count;
  sample_t           centre [NUM_LANES];

  weighted_sum_hysteresis_trigger dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_sample_one      (in_sample_one),
    .in_sample_two      (in_sample_two),
    .in_sample_three    (in_sample_three),
    .in_sample_four     (in_sample_four),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_trigger        (out_trigger),
    .out_weighted_total (out_weighted_total),
    .out_difference     (out_difference),
    .out_baseline_now   (out_baseline_now),
    .out_rezeroed       (out_rezeroed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: drop ready on a share of cycles set by the current idling mode.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check every result transfer against the oldest outstanding reading.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_trigger, out_weighted_total, out_difference,
                         out_baseline_now, out_rezeroed);
    end
  end

  // Watchdog: end the run with an error once the cycle limit is reached.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[weighted_sum_hysteresis_trigger] ERROR");
    $finish;
  end

  function automatic sample_t clamp_sample(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_TOP) return sample_t'(SAMPLE_TOP);
    return sample_t'(v);
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_one(int a, int b, int c, int d);
    case ($urandom_range(0, 3))
      0:       return a;
      1:       return b;
      2:       return c;
      default: return d;
    endcase
  endfunction

  // Present one item, idling first at random; hold valid and payload until the
  // transfer, then record it. Valid is left high for a following item.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input sample_t s [NUM_LANES]);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_sample_one   <= s[0];
    in_sample_two   <= s[1];
    in_sample_three <= s[2];
    in_sample_four  <= s[3];
    do @(posedge clk); while (!in_ready);
    board.note_input(cmd, s);
    sent_items++;
  endtask

  // Drop valid, wait for every owed reading, then let the pipeline empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Caller lowers cfg_valid once its run of writes is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.apply_config(idx, data);
  endtask

  // Gain writes carry junk in the upper byte, which the block must discard.
  task automatic load_setting(input logic [GAIN_W-1:0] g [NUM_LANES],
                              input logic [LEVEL_W-1:0] hi, input logic [LEVEL_W-1:0] lo,
                              input logic [LEVEL_W-1:0] tol, input bit poke_unused);
    write_reg(CFG_GAIN_ONE,   {8'($urandom_range(0, 255)), g[0]});
    write_reg(CFG_GAIN_TWO,   {8'($urandom_range(0, 255)), g[1]});
    write_reg(CFG_GAIN_THREE, {8'($urandom_range(0, 255)), g[2]});
    write_reg(CFG_GAIN_FOUR,  {8'($urandom_range(0, 255)), g[3]});
    write_reg(CFG_LEVEL_HIGH, hi);
    write_reg(CFG_LEVEL_LOW,  lo);
    write_reg(CFG_TOLERANCE,  tol);
    if (poke_unused) write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  // Startup window around the current centre, now and then with an outlier
  // that the trimmed mean should throw away.
  task automatic run_startup(input int noise);
    sample_t s [NUM_LANES];
    for (int i = 0; i < START_WINDOW_DEF; i++) begin
      foreach (s[c]) begin
        if ($urandom_range(0, 7) == 0) s[c] = sample_t'($urandom_range(0, SAMPLE_TOP));
        else s[c] = clamp_sample(int'(centre[c]) + jitter(noise));
      end
      send_item(CMD_START, s);
    end
  endtask

  // Measures on a drifting random walk so the difference wanders across both levels.
  task automatic run_measures(input int count, input int step);
    sample_t s [NUM_LANES];
    int      offset [NUM_LANES];
    int      drift;
    drift = ($urandom_range(0, 1) == 1) ? step / 2 : -(step / 2);
    foreach (offset[c]) offset[c] = 0;
    for (int i = 0; i < count; i++) begin
      foreach (s[c]) begin
        offset[c] += drift + jitter(step);
        s[c] = clamp_sample(int'(centre[c]) + offset[c]);
      end
      send_item(($urandom_range(0, 9) == 0) ? CMD_SPARE : CMD_MEASURE, s);
    end
  endtask

  // Calibration ticks with bounded noise; a few plain measures mixed in must
  // not advance the block count.
  task automatic run_ticks(input int count, input int noise, input bit mixed);
    sample_t s [NUM_LANES];
    for (int i = 0; i < count; i++) begin
      foreach (s[c]) s[c] = clamp_sample(int'(centre[c]) + jitter(noise));
      if (mixed && $urandom_range(0, 3) == 0) send_item(CMD_MEASURE, s);
      else send_item(CMD_TICK, s);
    end
  endtask

  task automatic run_noise(input int count);
    sample_t s [NUM_LANES];
    for (int i = 0; i < count; i++) begin
      foreach (s[c]) s[c] = sample_t'($urandom_range(0, SAMPLE_TOP));
      send_item(CMD_W'($urandom_range(0, 3)), s);
    end
  endtask

  task automatic new_centre();
    foreach (centre[c]) begin
      case ($urandom_range(0, 5))
        0:       centre[c] = '0;
        1:       centre[c] = sample_t'(SAMPLE_TOP);
        default: centre[c] = sample_t'($urandom_range(0, SAMPLE_TOP));
      endcase
    end
  endtask

  initial begin : stimulus
    sample_t           s [NUM_LANES];
    logic [GAIN_W-1:0] g [NUM_LANES];
    logic [LEVEL_W-1:0] hi;
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] tol;
    int                 v;
    int unsigned        target;
    int unsigned        pick;

    board           = new();
    send_gap_pct    = 25;
    recv_stall_pct  = 64;
    sent_items      = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = CMD_MEASURE;
    in_sample_one   = '0;
    in_sample_two   = '0;
    in_sample_three = '0;
    in_sample_four  = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_GAIN_ONE;
    cfg_data        = '0;
    foreach (centre[c]) centre[c] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full-scale measure sets the trigger, spare code with zeros clears it.
    foreach (s[c]) s[c] = sample_t'(SAMPLE_TOP);
    send_item(CMD_MEASURE, s);
    foreach (s[c]) s[c] = '0;
    send_item(CMD_SPARE, s);

    // Startup window with trimmed outliers; disable channel two mid-window so the
    // gains at the close decide the baseline (three channels of mean 100 -> 3000).
    s = '{12'd100, 12'd4095, 12'd100, 12'd99};
    send_item(CMD_START, s);
    s = '{12'd0, 12'd4095, 12'd100, 12'd101};
    send_item(CMD_START, s);
    drain();
    write_reg(CFG_GAIN_TWO, 16'd0);
    cfg_valid <= 1'b0;
    s = '{12'd4095, 12'd4095, 12'd100, 12'd100};
    send_item(CMD_START, s);
    s = '{12'd100, 12'd4095, 12'd100, 12'd100};
    send_item(CMD_START, s);
    send_item(CMD_START, s);

    // One calibration block through the hysteresis band: hold, set at the high
    // level, hold at exactly the low level, clear just below it; the spread stays
    // inside the tolerance, so the closing tick re-zeroes.
    for (int k = 0; k < BLOCK_LENGTH_DEF; k++) begin
      case (k)
        0, 2:    v = 620;
        1:       v = 640;
        3:       v = 600;
        4:       v = 599;
        default: v = 600 + (k % 3);
      endcase
      s = '{sample_t'(v / 3), sample_t'(SAMPLE_TOP), sample_t'(v / 3),
            sample_t'(v - 2 * (v / 3))};
      send_item(CMD_TICK, s);
    end

    // Random phases, each under its own setting; the defaults and the extremes first.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_gap_pct   = 25;
        recv_stall_pct = 64;
      end else if (p < 6) begin
        send_gap_pct   = 64;
        recv_stall_pct = 25;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      drain();
      case (p)
        0: begin
          foreach (g[c]) g[c] = GAIN_RESET;
          hi  = LEVEL_HIGH_RESET;
          lo  = LEVEL_LOW_RESET;
          tol = TOLERANCE_RESET;
        end
        1: begin
          foreach (g[c]) g[c] = '1;
          hi  = '1;
          lo  = '1;
          tol = '1;
        end
        2: begin
          foreach (g[c]) g[c] = '0;
          hi  = '0;
          lo  = '0;
          tol = '0;
        end
        3: begin
          // clear level above set level
          g   = '{8'd1, 8'd0, 8'd255, 8'd7};
          hi  = 16'd1000;
          lo  = 16'd2000;
          tol = '0;
        end
        default: begin
          foreach (g[c]) g[c] = ($urandom_range(0, 5) == 0) ? '0 : 8'($urandom_range(1, 255));
          lo  = 16'($urandom_range(0, 20000));
          hi  = 16'(lo + $urandom_range(0, 4000));
          tol = 16'($urandom_range(0, 3000));
        end
      endcase
      load_setting(g, hi, lo, tol, p == 4);
      new_centre();

      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          new_centre();
          run_startup(pick_one(0, 3, 40, SAMPLE_TOP));
        end else if (pick < 45) begin
          run_measures($urandom_range(5, 25), pick_one(1, 8, 40, 400));
        end else if (pick < 80) begin
          if ($urandom_range(0, 3) == 0) run_ticks($urandom_range(5, 30), pick_one(0, 1, 5, 60), 1'b1);
          else run_ticks(BLOCK_LENGTH_DEF, pick_one(0, 1, 5, 60), 1'b0);
        end else begin
          run_noise($urandom_range(1, 8));
        end
      end
    end

    drain();
    if (board.mismatches == 0) begin
      $display("[weighted_sum_hysteresis_trigger] OK");
    end else begin
      $display("[weighted_sum_hysteresis_trigger] ERROR");
    end
    $finish;
  end

endmodule
